>>> hdl/multi_channel_pulse_power_meter_assert.svh
// ----------------------------------------------------------------------------
// Pulse power meter assertion macros
// Shorthand for the clocked, reset-qualified property checks of the meter.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PULSE_POWER_METER_ASSERT_SVH
`define MULTI_CHANNEL_PULSE_POWER_METER_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define MCPPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define MCPPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mcppm_pkg.sv
// ----------------------------------------------------------------------------
// Pulse power meter package
// Shared widths, constants, state encoding and status types of the meter.
// ----------------------------------------------------------------------------
package mcppm_pkg;

    // Field widths.
    localparam int CH_W     = 3;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int RATE_W   = 32;
    localparam int SCALE_W  = 16;

    // Dividend of the rate division: scale times 1e8 fits in 43 bits.
    localparam int NUM_W    = 43;
    localparam int UNIT_W   = 27;
    localparam logic [UNIT_W-1:0] RATE_UNIT = 27'd100000000;

    // Divider step counter.
    localparam int STEP_CNT_W = $clog2(NUM_W + 1);

    // Result payload: count, period_valid, period, rate, saturated, padding.
    localparam int OUT_BITS    = COUNT_W + 1 + TIME_W + RATE_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    // Per-channel memory word: pulse count and last edge time.
    localparam int WORD_W = COUNT_W + TIME_W;

    // Control sequence of one edge.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } state_t;

    // Divider status toward the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hdl/mcppm_state_mem.sv
// ----------------------------------------------------------------------------
// Pulse power meter channel state memory
// One word per channel (count, last time) with a registered read port and
// per-entry seen bits; an entry never written reads as zero and not seen.
// ----------------------------------------------------------------------------
module mcppm_state_mem #(
    parameter int CHANNELS = 6,
    parameter int IDX_W    = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic [mcppm_pkg::COUNT_W-1:0] rd_count,
    output logic [mcppm_pkg::TIME_W-1:0]  rd_time,
    output logic                          rd_seen,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [mcppm_pkg::COUNT_W-1:0] wr_count,
    input  logic [mcppm_pkg::TIME_W-1:0]  wr_time
);

    logic [mcppm_pkg::WORD_W-1:0] store_reg [CHANNELS];
    logic [CHANNELS-1:0]          seen_reg;
    logic [mcppm_pkg::WORD_W-1:0] rd_word_reg;
    logic                         rd_seen_reg;

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= {wr_time, wr_count};
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg <= store_reg[rd_addr];
        end
    end

    // Seen bits, cleared at reset; the read copy follows the word read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            rd_seen_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                seen_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_seen_reg <= seen_reg[rd_addr];
            end
        end
    end

    // An entry not yet written reads as its reset value of zero.
    assign rd_seen  = rd_seen_reg;
    assign rd_count = rd_seen_reg ? rd_word_reg[mcppm_pkg::COUNT_W-1:0] : '0;
    assign rd_time  = rd_seen_reg ? rd_word_reg[mcppm_pkg::WORD_W-1:mcppm_pkg::COUNT_W] : '0;

endmodule

>>> hdl/mcppm_divider.sv
// ----------------------------------------------------------------------------
// Pulse power meter divider
// Restoring radix-2 divider, one quotient bit per cycle, 43 by 32 bits.
// ----------------------------------------------------------------------------
module mcppm_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mcppm_pkg::NUM_W-1:0]   dividend,
    input  logic [mcppm_pkg::TIME_W-1:0]  divisor,
    output logic [mcppm_pkg::NUM_W-1:0]   quotient,
    output mcppm_pkg::div_stat_t          stat
);

    logic [mcppm_pkg::NUM_W-1:0]      quo_reg;
    logic [mcppm_pkg::TIME_W-1:0]     rem_reg;
    logic [mcppm_pkg::TIME_W-1:0]     div_reg;
    logic [mcppm_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [mcppm_pkg::TIME_W:0]       partial;
    logic [mcppm_pkg::TIME_W:0]       diff;
    logic                             fits;
    logic [mcppm_pkg::TIME_W-1:0]     rem_next;

    // One trial subtraction of the shifted partial remainder.
    always_comb begin
        partial  = {rem_reg, quo_reg[mcppm_pkg::NUM_W-1]};
        diff     = partial - {1'b0, div_reg};
        fits     = (partial >= {1'b0, div_reg});
        rem_next = fits ? diff[mcppm_pkg::TIME_W-1:0] : partial[mcppm_pkg::TIME_W-1:0];
    end

    // Operand and quotient shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[mcppm_pkg::NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    // Step counter and status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= mcppm_pkg::STEP_CNT_W'(mcppm_pkg::NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mcppm_pkg::STEP_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hdl/multi_channel_pulse_power_meter.sv
// ----------------------------------------------------------------------------
// Multi-channel pulse power meter
// Counts edges per channel, measures the period since the previous edge and
// returns the rate energy_scale * 1e8 / period, saturated to 32 bits.
// ----------------------------------------------------------------------------
// Sequence: memory read, update, divider steps and result load when a division
//   runs; first edges and zero periods skip the divider steps.
// Throughput: one edge at a time; with a division the one-bit-per-cycle divider
//   sets the pace, and a stalled result side holds off further edges.
// Reset: aresetn clears all seen bits at once, so every count and time reads
//   as zero, sets energy_scale to 1 and empties the result register.
module multi_channel_pulse_power_meter #(
    parameter int CHANNELS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: energy_scale.
    input  logic                              cfg_wr_en,
    input  logic [mcppm_pkg::SCALE_W-1:0]     cfg_wr_data,
    // Input edges.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mcppm_pkg::TIME_W-1:0]      s_tdata,  // [31:0] timestamp_us
    input  logic [mcppm_pkg::CH_W-1:0]        s_tuser,  // [2:0] channel
    // Results.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pulse_count, [32] period_valid, [64:33] period_us,
    // [96:65] rate_centi, [97] rate_saturated, [103:98] zero
    output logic [mcppm_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [mcppm_pkg::CH_W-1:0]        m_tuser   // [2:0] channel_out
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mcppm_pkg::state_t state_reg;
    mcppm_pkg::state_t state_next;

    logic [mcppm_pkg::SCALE_W-1:0]     scale_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic [mcppm_pkg::CH_W-1:0]        ch_reg;
    logic [mcppm_pkg::TIME_W-1:0]      ts_reg;
    logic [mcppm_pkg::COUNT_W-1:0]     count_reg;
    logic [mcppm_pkg::TIME_W-1:0]      period_reg;
    logic                              seen_reg;
    logic [mcppm_pkg::NUM_W-1:0]       num_reg;
    logic [mcppm_pkg::RATE_W-1:0]      rate_reg;
    logic                              sat_reg;

    logic                              m_tvalid_reg;
    logic [mcppm_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [mcppm_pkg::CH_W-1:0]        m_tuser_reg;

    logic                              in_xfer;
    logic                              ch_ok;
    logic                              rd_en;
    logic                              wr_en;
    logic                              div_start;
    logic                              out_load;

    logic [mcppm_pkg::COUNT_W-1:0]     rd_count;
    logic [mcppm_pkg::TIME_W-1:0]      rd_time;
    logic                              rd_seen;
    logic [mcppm_pkg::NUM_W-1:0]       quotient;
    mcppm_pkg::div_stat_t              div_stat;

    // Channel state memory.
    mcppm_state_mem #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_state_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (IDX_W'(s_tuser)),
        .rd_count (rd_count),
        .rd_time  (rd_time),
        .rd_seen  (rd_seen),
        .wr_en    (wr_en),
        .wr_addr  (idx_reg),
        .wr_count (count_reg),
        .wr_time  (ts_reg)
    );

    // Rate divider.
    mcppm_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (period_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Handshake and control strobes.
    always_comb begin
        s_tready  = (state_reg == mcppm_pkg::ST_IDLE);
        in_xfer   = s_tvalid && s_tready;
        ch_ok     = ({29'd0, s_tuser} < 32'(CHANNELS));
        rd_en     = in_xfer && ch_ok;
        wr_en     = (state_reg == mcppm_pkg::ST_CALC);
        div_start = (state_reg == mcppm_pkg::ST_CALC) && seen_reg && (period_reg != '0);
        out_load  = (state_reg == mcppm_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcppm_pkg::ST_IDLE: begin
                if (rd_en) begin
                    state_next = mcppm_pkg::ST_READ;
                end
            end
            mcppm_pkg::ST_READ: begin
                state_next = mcppm_pkg::ST_CALC;
            end
            mcppm_pkg::ST_CALC: begin
                state_next = div_start ? mcppm_pkg::ST_DIV : mcppm_pkg::ST_OUT;
            end
            mcppm_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = mcppm_pkg::ST_OUT;
                end
            end
            mcppm_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = mcppm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mcppm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mcppm_pkg::ST_IDLE;
            scale_reg    <= mcppm_pkg::SCALE_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Edge datapath: capture, update, special cases and division result.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            idx_reg <= IDX_W'(s_tuser);
            ch_reg  <= s_tuser;
            ts_reg  <= s_tdata;
        end
        if (state_reg == mcppm_pkg::ST_READ) begin
            count_reg  <= rd_count + 1'b1;
            period_reg <= rd_seen ? (ts_reg - rd_time) : '0;
            seen_reg   <= rd_seen;
            num_reg    <= mcppm_pkg::NUM_W'(scale_reg) * mcppm_pkg::NUM_W'(mcppm_pkg::RATE_UNIT);
        end
        if (state_reg == mcppm_pkg::ST_CALC) begin
            if (!seen_reg) begin
                rate_reg <= '0;
                sat_reg  <= 1'b0;
            end else begin
                rate_reg <= '1;
                sat_reg  <= 1'b1;
            end
        end
        if ((state_reg == mcppm_pkg::ST_DIV) && div_stat.done) begin
            if (quotient[mcppm_pkg::NUM_W-1:mcppm_pkg::RATE_W] != '0) begin
                rate_reg <= '1;
                sat_reg  <= 1'b1;
            end else begin
                rate_reg <= quotient[mcppm_pkg::RATE_W-1:0];
                sat_reg  <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{mcppm_pkg::OUT_PAD_W{1'b0}}, sat_reg, rate_reg, period_reg,
                            seen_reg, count_reg};
            m_tuser_reg <= ch_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `include "multi_channel_pulse_power_meter_assert.svh"

    // A first edge carries neither a period nor a rate.
    `MCPPM_ASSERT_IMP(a_first_edge_clean, m_tvalid && !m_tdata[32], m_tdata[97:33] == '0, "first edge result carries a period or rate")

    // The divider only runs while the controller waits for it.
    `MCPPM_ASSERT_IMP(a_div_owned, div_stat.busy || div_stat.done, state_reg == mcppm_pkg::ST_DIV, "divider active outside the divide state")

    // An in-range edge always starts a memory read sequence.
    `MCPPM_ASSERT_NXT(a_edge_reads, rd_en, state_reg == mcppm_pkg::ST_READ, "accepted edge did not start a read")

endmodule

>>> bench/multi_channel_pulse_power_meter_tb.sv
// ----------------------------------------------------------------------------
// Pulse power meter testbench
// Sends rising edges on the meter channels with random gaps on both sides of
// the handshake. Every reading is checked against a per-channel count, period
// and rate prediction that the bench keeps for itself.
// ----------------------------------------------------------------------------
module multi_channel_pulse_power_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = 6;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASES        = 7;
    localparam int REPORT_LIMIT  = 10;
    localparam longint unsigned CENTI_PER_SECOND = 64'd100000000;
    localparam logic [mcppm_pkg::RATE_W-1:0] RATE_MAX = '1;

    // One reading of the meter, split into its fields.
    typedef struct {
        logic [mcppm_pkg::CH_W-1:0]    channel;
        logic [mcppm_pkg::COUNT_W-1:0] count;
        logic                          period_valid;
        logic [mcppm_pkg::TIME_W-1:0]  period;
        logic [mcppm_pkg::RATE_W-1:0]  rate;
        logic                          saturated;
    } meter_reading_t;

    // Per-channel pulse bookkeeping and the queue of readings still owed.
    class pulse_rate_tracker;
        logic [mcppm_pkg::SCALE_W-1:0] energy_scale;
        logic [mcppm_pkg::COUNT_W-1:0] edge_count [CHANNELS];
        logic [mcppm_pkg::TIME_W-1:0]  last_time [CHANNELS];
        bit                            edge_seen [CHANNELS];
        meter_reading_t                owed [$];
        int                            errors;

        function new();
            energy_scale = 1;
            errors = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                edge_count[i] = '0;
                last_time[i]  = '0;
                edge_seen[i]  = 1'b0;
            end
        endfunction

        function void set_scale(logic [mcppm_pkg::SCALE_W-1:0] value);
            energy_scale = value;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function string show(meter_reading_t r);
            return $sformatf("ch=%0d count=%0d pv=%0b period=%0d rate=%0d sat=%0b",
                             r.channel, r.count, r.period_valid, r.period, r.rate,
                             r.saturated);
        endfunction

        // Works out the reading caused by one accepted edge.
        function void note_edge(logic [mcppm_pkg::CH_W-1:0] channel,
                                logic [mcppm_pkg::TIME_W-1:0] stamp);
            meter_reading_t  r;
            longint unsigned quotient;
            int              idx;
            if (channel >= CHANNELS) begin
                return;
            end
            idx = int'(channel);
            edge_count[idx] = edge_count[idx] + 1'b1;
            r.channel      = channel;
            r.count        = edge_count[idx];
            r.period_valid = 1'b0;
            r.period       = '0;
            r.rate         = '0;
            r.saturated    = 1'b0;
            if (edge_seen[idx]) begin
                r.period_valid = 1'b1;
                r.period       = stamp - last_time[idx];
                if (r.period == '0) begin
                    // A zero period has no finite rate.
                    r.rate      = RATE_MAX;
                    r.saturated = 1'b1;
                end else begin
                    quotient = (64'(energy_scale) * CENTI_PER_SECOND) / 64'(r.period);
                    if (quotient > 64'(RATE_MAX)) begin
                        r.rate      = RATE_MAX;
                        r.saturated = 1'b1;
                    end else begin
                        r.rate = quotient[mcppm_pkg::RATE_W-1:0];
                    end
                end
            end
            last_time[idx] = stamp;
            edge_seen[idx] = 1'b1;
            owed.push_back(r);
        endfunction

        // Compares one transfer on the result side with the oldest owed reading.
        function void check_reading(logic [mcppm_pkg::CH_W-1:0] user,
                                    logic [mcppm_pkg::OUT_TDATA_W-1:0] data);
            meter_reading_t got;
            meter_reading_t want;
            bit             bad;
            got.channel      = user;
            got.count        = data[31:0];
            got.period_valid = data[32];
            got.period       = data[64:33];
            got.rate         = data[96:65];
            got.saturated    = data[97];
            if (owed.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: reading with none owed: %s", $time, show(got));
                end
                return;
            end
            want = owed.pop_front();
            bad = (got.channel != want.channel) || (got.count != want.count) ||
                  (got.period_valid != want.period_valid) ||
                  (got.period != want.period) || (got.rate != want.rate) ||
                  (got.saturated != want.saturated) ||
                  (data[mcppm_pkg::OUT_TDATA_W-1:mcppm_pkg::OUT_BITS] != '0);
            if (bad) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: reading mismatch (padding %0h)", $time,
                             data[mcppm_pkg::OUT_TDATA_W-1:mcppm_pkg::OUT_BITS]);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [mcppm_pkg::SCALE_W-1:0]     cfg_wr_data = '0;
    logic                              s_tvalid    = 1'b0;
    logic                              s_tready;
    logic [mcppm_pkg::TIME_W-1:0]      s_tdata     = '0;  // [31:0] timestamp_us
    logic [mcppm_pkg::CH_W-1:0]        s_tuser     = '0;  // [2:0] channel
    logic                              m_tvalid;
    logic                              m_tready    = 1'b0;
    // [31:0] pulse_count, [32] period_valid, [64:33] period_us,
    // [96:65] rate_centi, [97] rate_saturated, [103:98] zero
    logic [mcppm_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [mcppm_pkg::CH_W-1:0]        m_tuser;               // [2:0] channel_out

    pulse_rate_tracker            tracker;
    logic [mcppm_pkg::TIME_W-1:0] next_stamp [CHANNELS];
    bit                           long_hold_req = 1'b0;
    bit                           sender_calm   = 1'b1;

    multi_channel_pulse_power_meter #(
        .CHANNELS (CHANNELS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Check every reading on the transfer edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_reading(m_tuser, m_tdata);
        end
    end

    // Result-side ready: runs of ready and stall, now and then one long hold.
    initial begin : result_ready_driver
        int run_left;
        bit run_ready;
        int pick;
        run_left  = 0;
        run_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(1, 20);
                    end else if (pick < 60) begin
                        run_ready = 1'b1;
                        run_left  = $urandom_range(100, 300);
                    end else if (pick < 90) begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(1, 3);
                    end else if (pick < 98) begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(4, 15);
                    end else begin
                        run_ready = 1'b0;
                        run_left  = $urandom_range(30, 100);
                    end
                end
                m_tready <= run_ready;
                run_left--;
            end
        end
    end

    // Idle cycles before the next edge: mostly none or short, a few long.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_calm || pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 150);
    endfunction

    // Offers one edge after the given gap and holds it until it is taken.
    task automatic send_edge(input logic [mcppm_pkg::CH_W-1:0] channel,
                             input logic [mcppm_pkg::TIME_W-1:0] stamp,
                             input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= channel;
        s_tdata  <= stamp;
        do @(posedge aclk); while (!s_tready);
        tracker.note_edge(channel, stamp);
    endtask

    // Stops sending and waits until every owed reading is in and the block is idle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_scale(input logic [mcppm_pkg::SCALE_W-1:0] value);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_scale(value);
    endtask

    // Mostly a plausible next edge on a real channel, with varied periods.
    task automatic random_edge();
        logic [mcppm_pkg::CH_W-1:0]   channel;
        logic [mcppm_pkg::TIME_W-1:0] stamp;
        logic [mcppm_pkg::TIME_W-1:0] delta;
        int                           pick;
        if ($urandom_range(0, 99) < 3) begin
            channel = mcppm_pkg::CH_W'($urandom_range(CHANNELS, 7));
        end else begin
            channel = mcppm_pkg::CH_W'($urandom_range(0, CHANNELS - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            delta = '0;
        end else if (pick < 25) begin
            delta = $urandom_range(1, 3000);
        end else if (pick < 70) begin
            delta = $urandom_range(1000, 2000000);
        end else if (pick < 85) begin
            delta = $urandom;
        end else begin
            delta = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        end
        if (channel < CHANNELS) begin
            stamp = (pick >= 95) ? $urandom : next_stamp[channel] + delta;
            next_stamp[channel] = stamp;
        end else begin
            stamp = $urandom;
        end
        send_edge(channel, stamp, pick_gap());
    endtask

    // Main sequence: directed edges, then random phases at several scales.
    initial begin : stimulus
        logic [mcppm_pkg::SCALE_W-1:0] scale;
        tracker = new();
        for (int i = 0; i < CHANNELS; i++) begin
            next_stamp[i] = $urandom;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Default scale: first edge, zero period, shortest and longest periods, wrap.
        send_edge(3'd0, 32'd0, 0);
        send_edge(3'd0, 32'd0, 0);
        send_edge(3'd0, 32'd1, 0);
        send_edge(3'd0, 32'hFFFF_FFFF, 0);
        send_edge(3'd0, 32'd5, 0);
        send_edge(3'd5, 32'hFFFF_FFFF, 0);
        send_edge(3'd5, 32'd99, 0);
        // Channels past the last one are ignored.
        send_edge(3'd6, 32'd123, 0);
        send_edge(3'd7, 32'hFFFF_FFFF, 0);
        send_edge(3'd1, 32'd7, 0);
        send_edge(3'd2, 32'd0, 0);
        send_edge(3'd3, 32'd1000, 0);
        send_edge(3'd4, 32'h8000_0000, 0);
        send_edge(3'd4, 32'h8000_0003, 0);

        // Largest scale: the rate overflows just below a period of 1526 us.
        write_scale(16'hFFFF);
        send_edge(3'd1, 32'd8, 0);
        send_edge(3'd1, 32'd1533, 0);
        send_edge(3'd1, 32'd3059, 0);
        send_edge(3'd2, 32'hFFFF_FFFF, 0);

        // Zero scale: the rate is zero unless the period is zero too.
        write_scale(16'h0000);
        send_edge(3'd3, 32'd2000, 0);
        send_edge(3'd3, 32'd2000, 0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       scale = 16'd1;
                1:       scale = 16'hFFFF;
                2:       scale = $urandom_range(2, 65534);
                3:       scale = $urandom_range(1, 200);
                4:       scale = 16'hFFFF;
                5:       scale = $urandom_range(1, 65535);
                default: scale = $urandom_range(1000, 65535);
            endcase
            write_scale(scale);
            sender_calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 40) begin
                    sender_calm = 1'b0;
                end
                // Hold the result side off while edges keep coming.
                if (p == 2 && i == 100) begin
                    long_hold_req = 1'b1;
                end
                // Pause the sender until the block has caught up.
                if (p == 4 && i == 100) begin
                    drain();
                end
                random_edge();
            end
        end

        drain();
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #(50_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
